// ----- rtl/kwms_pkg.sv -----
// Shared types and constants of the k-way merge selector.
package kwms_pkg;

  localparam int unsigned RUN_W = 3;
  localparam int unsigned KEY_W = 64;
  localparam int unsigned LEN_W = 32;
  localparam int unsigned CFG_W = 4;

  // Number of runs that the run index field can address.
  localparam int unsigned RUN_REACH = 8;

  localparam logic [CFG_W-1:0] RUNS_RESET = 4'd2;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_END    = 1'b1;

  localparam logic KIND_RECORD   = 1'b0;
  localparam logic KIND_FINISHED = 1'b1;

  typedef struct packed {
    logic             action;
    logic [RUN_W-1:0] run_index;
    logic [KEY_W-1:0] record_key;
    logic [LEN_W-1:0] record_len;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [RUN_W-1:0] out_run;
    logic [KEY_W-1:0] out_key;
    logic [LEN_W-1:0] out_len;
  } out_item_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    logic     in_range;
    in_item_t item;
  } task_t;

endpackage

// ----- rtl/kwms_front.sv -----
// Front end: run count register and classification of incoming items.
module kwms_front import kwms_pkg::*; #(
  parameter int unsigned RUN_SLOTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output task_t            q_task_o,
  output logic [CFG_W-1:0] runs_o
);

  logic [CFG_W-1:0] runs_in_use_q;
  logic [CFG_W-1:0] runs_in_use_d;

  assign cfg_ready_o   = 1'b1;
  assign runs_in_use_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : runs_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      runs_in_use_q <= RUNS_RESET;
    end else begin
      runs_in_use_q <= runs_in_use_d;
    end
  end

  // Clamp the programmed count to the runs that exist, and a zero count to one.
  always_comb begin
    if (runs_in_use_q == '0) begin
      runs_o = CFG_W'(1);
    end else if (runs_in_use_q > CFG_W'(RUN_SLOTS)) begin
      runs_o = CFG_W'(RUN_SLOTS);
    end else begin
      runs_o = runs_in_use_q;
    end
  end

  assign in_stall_o        = q_full_i;
  assign q_push_o          = in_valid_i && !q_full_i;
  assign q_task_o.item     = in_data_i;
  assign q_task_o.in_range = {1'b0, in_data_i.run_index} < runs_o;

endmodule

// ----- rtl/kwms_queue.sv -----
// Two-entry queue of classified items between the front and the back.
module kwms_queue import kwms_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t push_data_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output task_t pop_data_o
);

  task_t       slot_q [2];
  logic        wr_ptr_q;
  logic        wr_ptr_d;
  logic        rd_ptr_q;
  logic        rd_ptr_d;
  logic [1:0]  cnt_q;
  logic [1:0]  cnt_d;
  logic        do_pop;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/kwms_back.sv -----
// Back end: per-run status, sorted head list, selection and result register.
module kwms_back import kwms_pkg::*; #(
  parameter int unsigned RUN_SLOTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] runs_i,
  input  logic             q_valid_i,
  input  task_t            q_task_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  localparam int unsigned LD = RUN_SLOTS;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [RUN_W-1:0] run;
    logic [LEN_W-1:0] len;
  } head_t;

  function automatic logic head_less(head_t a, head_t b);
    return {a.key, a.run} < {b.key, b.run};
  endfunction

  // Status per run.
  logic [RUN_SLOTS-1:0] hv_q, hv_d, ended_q, ended_d;
  logic                 finished_q, finished_d;

  // Heads sorted by key then run; valid entries form a prefix.
  head_t                l_q [LD];
  head_t                l_d [LD];
  logic  [LD-1:0]       lval_q, lval_d;

  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q, out_data_d;

  logic                 go;
  logic                 apply, ins, fin_end, cond, emit_rec, emit_fin;
  logic [RUN_SLOTS-1:0] run_hit, in_use, hv1, ended1, rem_mask;
  logic                 held, ended_run;
  head_t                new_hd, sel_hd;
  logic  [LD-1:0]       lt;
  logic  [LD:0]         prev_lt, lt_pad;
  head_t                ls [LD+1];
  head_t                lp [LD+1];
  logic  [LD:0]         ls_v, lp_v;
  head_t                m [LD+1];
  logic  [LD:0]         mv, elig, first, pre, aft;
  logic                 any_elig;

  assign go      = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = go;

  assign new_hd.key = q_task_i.item.record_key;
  assign new_hd.run = q_task_i.item.run_index;
  assign new_hd.len = q_task_i.item.record_len;

  always_comb begin
    for (int i = 0; i < RUN_SLOTS; i++) begin
      run_hit[i] = q_task_i.item.run_index == RUN_W'(i);
      in_use[i]  = CFG_W'(i) < runs_i;
    end
    held      = |(hv_q & run_hit);
    ended_run = |(ended_q & run_hit);
    apply     = !finished_q && q_task_i.in_range && !held && !ended_run;
    ins       = apply && (q_task_i.item.action == ACT_RECORD);
    fin_end   = apply && (q_task_i.item.action == ACT_END);
    hv1       = hv_q | (ins ? run_hit : '0);
    ended1    = ended_q | (fin_end ? run_hit : '0);
    cond      = !finished_q && (&((hv1 | ended1) | ~in_use));

    // Insertion point of the new head.
    for (int j = 0; j < LD; j++) begin
      lt[j] = lval_q[j] && head_less(l_q[j], new_hd);
    end
    prev_lt = {lt, 1'b1};
    lt_pad  = {1'b0, lt};

    ls[LD]   = '0;
    ls_v[LD] = 1'b0;
    lp[0]    = '0;
    lp_v[0]  = 1'b0;
    for (int j = 0; j < LD; j++) begin
      ls[j]     = l_q[j];
      ls_v[j]   = lval_q[j];
      lp[j+1]   = l_q[j];
      lp_v[j+1] = lval_q[j];
    end

    // Merged list with one extra slot.
    for (int j = 0; j <= LD; j++) begin
      if (!ins || lt_pad[j]) begin
        m[j]  = ls[j];
        mv[j] = ls_v[j];
      end else if (prev_lt[j]) begin
        m[j]  = new_hd;
        mv[j] = 1'b1;
      end else begin
        m[j]  = lp[j];
        mv[j] = lp_v[j];
      end
      elig[j] = mv[j] && ({1'b0, m[j].run} < runs_i);
    end

    // First eligible entry is the winner.
    pre[0] = 1'b0;
    for (int j = 1; j <= LD; j++) begin
      pre[j] = pre[j-1] || elig[j-1];
    end
    sel_hd = '0;
    for (int j = 0; j <= LD; j++) begin
      first[j] = elig[j] && !pre[j];
      aft[j]   = elig[j] || pre[j];
      sel_hd   = sel_hd | (first[j] ? m[j] : '0);
    end
    any_elig = |elig;
    emit_rec = cond && any_elig;
    emit_fin = cond && !any_elig;

    for (int j = 0; j < LD; j++) begin
      if (emit_rec && aft[j]) begin
        l_d[j]    = m[j+1];
        lval_d[j] = mv[j+1];
      end else begin
        l_d[j]    = m[j];
        lval_d[j] = mv[j];
      end
    end

    for (int i = 0; i < RUN_SLOTS; i++) begin
      rem_mask[i] = emit_rec && (sel_hd.run == RUN_W'(i));
    end
    hv_d       = hv1 & ~rem_mask;
    ended_d    = ended1;
    finished_d = finished_q || emit_fin;

    out_data_d = out_data_q;
    if (emit_rec) begin
      out_data_d.result_kind = KIND_RECORD;
      out_data_d.out_run     = sel_hd.run;
      out_data_d.out_key     = sel_hd.key;
      out_data_d.out_len     = sel_hd.len;
    end else if (emit_fin) begin
      out_data_d.result_kind = KIND_FINISHED;
      out_data_d.out_run     = '0;
      out_data_d.out_key     = '0;
      out_data_d.out_len     = '0;
    end

    if (go && (emit_rec || emit_fin)) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q        <= '0;
      ended_q     <= '0;
      finished_q  <= 1'b0;
      lval_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (go) begin
        hv_q       <= hv_d;
        ended_q    <= ended_d;
        finished_q <= finished_d;
        lval_q     <= lval_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      l_q        <= l_d;
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The sorted list holds exactly the heads marked valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(lval_q) == $countones(hv_q))
    else $error("head list size differs from head count");

  // Valid list entries form a prefix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((lval_q >> 1) & ~lval_q) == '0)
    else $error("head list has a hole");

  // A run that has ended never holds a head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hv_q & ended_q) == '0)
    else $error("ended run holds a head");

  // Once finished, no further result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q && !out_valid_q |=> !out_valid_q)
    else $error("result after merge finished");

endmodule

// ----- rtl/k_way_merge_selector_core.sv -----
// Top level of the k-way merge selector.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) carries one item
// per transfer: either the next record of a run or the end mark of that run.
// The output channel (out_valid_o, out_stall_i, out_data_o) carries merged
// records in ascending key order, ties going to the lower run index, and one
// finished result once every run in use has ended and no head is left.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes the
// number of runs in use; it is always ready and must only be written while no
// item is in flight.
// A result is presented in the cycle after the back end pops the item that
// causes it. Throughput: one item per cycle while out_stall_i is low; the back
// end's single insertion and selection step over the sorted head list sets it.
// A two-entry queue separates the front from the back, so a stalled receiver
// backs up into the queue first and in_stall_o rises only when it is full.
// A stalled result holds its value. Reset clears all heads, end marks and the
// finished flag and sets the run count to two; nothing needs a clearing pass.
module k_way_merge_selector_core import kwms_pkg::*; #(
  parameter int unsigned MAX_RUNS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  // Only the runs that the run index can address get storage.
  localparam int unsigned RUN_SLOTS = (MAX_RUNS < RUN_REACH) ? MAX_RUNS : RUN_REACH;

  logic             q_full;
  logic             q_push;
  logic             q_valid;
  logic             q_pop;
  task_t            q_task_in;
  task_t            q_task_out;
  logic [CFG_W-1:0] runs;

  // Front end: holds the run count and tags each item as in range or not.
  kwms_front #(
    .RUN_SLOTS (RUN_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_task_o    (q_task_in),
    .runs_o      (runs)
  );

  // Short queue so that the front keeps taking items while the back waits.
  kwms_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_task_in),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_task_out)
  );

  // Back end: applies each item, then, when every run in use holds a head or
  // has ended, emits the smallest eligible head or, if none, the finished result.
  kwms_back #(
    .RUN_SLOTS (RUN_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .runs_i      (runs),
    .q_valid_i   (q_valid),
    .q_task_i    (q_task_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench of the k-way merge selector core.
module tb;
  import kwms_pkg::*;

  // Number of runs the block is built for; it matches the default of the core.
  localparam int unsigned MAX_RUNS = 8;
  // Cycles to let pass after the last expected result before the block counts
  // as idle: room for the result register and the two-entry queue, with some margin.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned NUM_PHASES = 8;
  // Hard limit on the run, far above the slowest correct run.
  localparam int unsigned LIMIT_CYCLES = 400_000;

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    EXP_PRED,   // the predictor works the result out
    EXP_NONE,   // the item causes no result
    EXP_GIVEN   // the result is typed into the row
  } exp_mode_e;

  typedef struct {
    bit          is_cfg;
    logic [3:0]  cfg;
    in_item_t    item;
    exp_mode_e   how;
    out_item_t   want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;

  // Percent of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;

  // Results still owed by the block, oldest first.
  out_item_t pending_results[$];

  // Shadow of the merge state, kept in step with every accepted transfer.
  logic [KEY_W-1:0] head_key[MAX_RUNS];
  logic [LEN_W-1:0] head_len[MAX_RUNS];
  bit               head_valid[MAX_RUNS];
  bit               run_ended[MAX_RUNS];
  bit               merge_done;
  logic [CFG_W-1:0] runs_reg;

  stim_row_t opening[$];
  stim_row_t closing[$];

  k_way_merge_selector_core #(
    .MAX_RUNS(MAX_RUNS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #10 clk = ~clk;

  // Number of runs that take part, with the register saturated to the range
  // that both the build and the run index field can reach.
  function automatic int unsigned live_runs();
    int unsigned n;
    int unsigned cap;
    n = {28'd0, runs_reg};
    cap = (MAX_RUNS < RUN_REACH) ? MAX_RUNS : RUN_REACH;
    if (n < 1) n = 1;
    if (n > cap) n = cap;
    return n;
  endfunction

  // Applies one accepted item to the shadow state and tells whether the block
  // owes a result for it. The item is applied first; then, if every run in use
  // holds a head or has ended, the smallest head leaves (ties to the lower
  // run), or the finished result goes out once no head is left.
  function automatic bit merge_step(input in_item_t it, output out_item_t res);
    int unsigned n;
    int unsigned r;
    int best;
    res = '0;
    n = live_runs();
    if (merge_done) return 1'b0;
    r = {29'd0, it.run_index};
    if (r < n && !head_valid[r] && !run_ended[r]) begin
      if (it.action == ACT_RECORD) begin
        head_key[r] = it.record_key;
        head_len[r] = it.record_len;
        head_valid[r] = 1'b1;
      end else begin
        run_ended[r] = 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!head_valid[i] && !run_ended[i]) return 1'b0;
    end
    best = -1;
    for (int i = 0; i < n; i++) begin
      if (head_valid[i] && (best < 0 || head_key[i] < head_key[best])) best = i;
    end
    if (best >= 0) begin
      res.result_kind = KIND_RECORD;
      res.out_run = best[RUN_W-1:0];
      res.out_key = head_key[best];
      res.out_len = head_len[best];
      head_valid[best] = 1'b0;
      return 1'b1;
    end
    merge_done = 1'b1;
    res.result_kind = KIND_FINISHED;
    return 1'b1;
  endfunction

  function automatic out_item_t merged(input int unsigned run, input logic [KEY_W-1:0] key,
                                       input logic [LEN_W-1:0] len);
    out_item_t o;
    o.result_kind = KIND_RECORD;
    o.out_run = RUN_W'(run);
    o.out_key = key;
    o.out_len = len;
    return o;
  endfunction

  function automatic stim_row_t item_row(input logic act, input int unsigned run,
                                         input logic [KEY_W-1:0] key,
                                         input logic [LEN_W-1:0] len,
                                         input exp_mode_e how, input out_item_t want);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cfg = '0;
    row.item.action = act;
    row.item.run_index = RUN_W'(run);
    row.item.record_key = key;
    row.item.record_len = len;
    row.how = how;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_W-1:0] v);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.cfg = v;
    row.item = '0;
    row.how = EXP_NONE;
    row.want = '0;
    return row;
  endfunction

  // Keys lean toward the extremes and toward a few small values, so that
  // ties between runs come up often.
  function automatic logic [KEY_W-1:0] any_key();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return KEY_W'($urandom_range(7));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] any_len();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Most items refill a run that is waiting, which keeps the merge moving.
  // The rest is noise: records and end marks to any run. An end mark is
  // permanent, so one that would really end a run is only let through when
  // may_end is set.
  function automatic in_item_t next_item(input bit may_end);
    in_item_t it;
    int unsigned n;
    int waiting[$];
    n = live_runs();
    for (int i = 0; i < n; i++) begin
      if (!head_valid[i] && !run_ended[i]) waiting = {waiting, i};
    end
    it.record_key = any_key();
    it.record_len = any_len();
    if (waiting.size() != 0 && $urandom_range(99) < 80) begin
      it.run_index = RUN_W'(waiting[$urandom_range(waiting.size() - 1)]);
      it.action = (may_end && $urandom_range(9) == 0) ? ACT_END : ACT_RECORD;
    end else begin
      it.run_index = RUN_W'($urandom_range(RUN_REACH - 1));
      it.action = ($urandom_range(1) == 0) ? ACT_RECORD : ACT_END;
      if (it.action == ACT_END && !may_end && it.run_index < n &&
          !head_valid[it.run_index] && !run_ended[it.run_index]) begin
        it.action = ACT_RECORD;
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one item, waits for its transfer and books what it should cause.
  // The valid stays high from one transfer to the next unless a gap is drawn.
  task automatic transfer(input in_item_t it, input exp_mode_e how, input out_item_t want);
    out_item_t res;
    bit hit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit = merge_step(it, res);
    case (how)
      EXP_PRED:  if (hit) pending_results = {pending_results, res};
      EXP_GIVEN: pending_results = {pending_results, want};
      default: ;
    endcase
  endtask

  // Lets every owed result arrive and then waits out the drain time, so that an item
  // that causes no result has left the block as well.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_runs(input logic [CFG_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    runs_reg = v;
  endtask

  task automatic play_rows(ref stim_row_t rows[$]);
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_runs(rows[i].cfg);
      end else begin
        transfer(rows[i].item, rows[i].how, rows[i].want);
      end
    end
  endtask

  // Receiver side: checks each result transfer against the oldest booked
  // result, then draws the stall for the next cycle. Values are read right at
  // the edge, before any of that edge's updates land.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unbooked result kind %0d run %0d key %h len %h",
                                  out_data.result_kind, out_data.out_run,
                                  out_data.out_key, out_data.out_len));
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_kind !== want.result_kind)
          report_mismatch($sformatf("result_kind %0d, wanted %0d",
                                    out_data.result_kind, want.result_kind));
        if (out_data.out_run !== want.out_run)
          report_mismatch($sformatf("out_run %0d, wanted %0d", out_data.out_run, want.out_run));
        if (out_data.out_key !== want.out_key)
          report_mismatch($sformatf("out_key %h, wanted %h", out_data.out_key, want.out_key));
        if (out_data.out_len !== want.out_len)
          report_mismatch($sformatf("out_len %h, wanted %h", out_data.out_len, want.out_len));
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #(20 * LIMIT_CYCLES);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    in_item_t it;
    logic [CFG_W-1:0] phase_runs[6];
    phase_runs = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd5, 4'd0};

    for (int i = 0; i < MAX_RUNS; i++) begin
      head_key[i] = '0;
      head_len[i] = '0;
      head_valid[i] = 1'b0;
      run_ended[i] = 1'b0;
    end
    merge_done = 1'b0;
    runs_reg = RUNS_RESET;

    // Opening table, two runs in use after reset. It walks through ties, the
    // key and length extremes, items that are ignored because the run holds a
    // head or is not in use, and the saturation of the run count. Lowering the
    // count while a higher run is still waiting makes the next item, even an
    // ignored one, release a result.
    opening = {opening, item_row(ACT_RECORD, 0, 64'd5, 32'd1, EXP_NONE, '0)};
    opening = {opening, item_row(ACT_RECORD, 0, 64'd7, 32'd2, EXP_NONE, '0)};
    opening = {opening, item_row(ACT_END, 0, '0, '0, EXP_NONE, '0)};
    opening = {opening, item_row(ACT_RECORD, 5, '1, '1, EXP_NONE, '0)};
    opening = {opening, item_row(ACT_RECORD, 1, 64'd5, '1, EXP_GIVEN,
                                 merged(0, 64'd5, 32'd1))};
    opening = {opening, item_row(ACT_RECORD, 0, '0, '0, EXP_GIVEN, merged(0, '0, '0))};
    opening = {opening, item_row(ACT_RECORD, 0, '1, '1, EXP_GIVEN, merged(1, 64'd5, '1))};
    opening = {opening, item_row(ACT_RECORD, 1, '1, '0, EXP_GIVEN, merged(0, '1, '1))};
    opening = {opening, cfg_row(4'd1)};
    opening = {opening, item_row(ACT_RECORD, 1, 64'd3, 32'd3, EXP_NONE, '0)};
    opening = {opening, item_row(ACT_RECORD, 0, 64'd8, 32'd8, EXP_GIVEN,
                                 merged(0, 64'd8, 32'd8))};
    opening = {opening, cfg_row(4'd15)};
    opening = {opening, item_row(ACT_RECORD, 7, 64'h8000_0000_0000_0000, 32'h8000_0000,
                                 EXP_PRED, '0)};
    opening = {opening, item_row(ACT_RECORD, 0, 64'd1, 32'h5555_5555, EXP_PRED, '0)};
    opening = {opening, cfg_row(4'd2)};
    opening = {opening, item_row(ACT_RECORD, 6, '0, '0, EXP_GIVEN,
                                 merged(0, 64'd1, 32'h5555_5555))};
    opening = {opening, cfg_row(4'd0)};
    opening = {opening, item_row(ACT_END, 3, '0, '0, EXP_NONE, '0)};
    opening = {opening, item_row(ACT_RECORD, 0, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA,
                                 EXP_GIVEN,
                                 merged(0, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA))};

    // Once the finished result is out, every item is ignored until reset.
    closing = {closing, item_row(ACT_RECORD, 0, '1, '1, EXP_NONE, '0)};
    closing = {closing, item_row(ACT_END, 0, '0, '0, EXP_NONE, '0)};
    closing = {closing, item_row(ACT_RECORD, 7, 64'd4, 32'd4, EXP_NONE, '0)};
    closing = {closing, item_row(ACT_END, 3, '0, '0, EXP_NONE, '0)};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    play_rows(opening);

    // Random phases, each with its own run count and idling pattern: none,
    // a mostly idle sender, a mostly stalling receiver, and both a little.
    // No run is ended here, since an end mark lasts until reset.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_runs((p < 6) ? phase_runs[p] : CFG_W'($urandom_range(15)));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        it = next_item(1'b0);
        transfer(it, EXP_PRED, '0);
      end
    end

    // Closing merge over all eight runs: runs now end one by one, the last
    // heads drain and the finished result goes out.
    write_runs(4'd8);
    send_idle_pct = 22;
    stall_pct = 22;
    while (!merge_done) begin
      it = next_item(1'b1);
      transfer(it, EXP_PRED, '0);
    end

    send_idle_pct = 0;
    stall_pct = 0;
    play_rows(closing);

    settle();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
